FILE: rtl/running_top_k_mean_macros.svh
// Assertion macros for the running top-k mean block.
`ifndef RUNNING_TOP_K_MEAN_MACROS_SVH
`define RUNNING_TOP_K_MEAN_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define RTKM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rtkm assertion failed");

// Next-cycle implication.
`define RTKM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rtkm assertion failed");

`else

`define RTKM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define RTKM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/rtkm_pkg.sv
`timescale 1ns / 1ps

package rtkm_pkg;

	localparam int SAMPLE_W = 32;
	localparam int TOP_W = 5;
	localparam logic [TOP_W-1:0] TOP_COUNT_RST = TOP_W'(5);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_WAIT,
		ST_DECIDE,
		ST_PREP,
		ST_DIV,
		ST_FIN,
		ST_OUT
	} state_t;

endpackage

FILE: rtl/running_top_k_mean.sv
`timescale 1ns / 1ps
// Running mean of the k largest samples of a sequence.
// Input channel: sample (signed Q16.16) and last_item, with sample_valid /
// sample_ready. One word in gives exactly one word out on the average channel
// (average_valid / average_ready): the sum of the held samples divided by k,
// truncated toward zero and saturated to 32 bits.
// Config: cfg_wr_en / cfg_wr_data write k (top_count) at once; write only
// while the block is idle. k of zero counts as one, k above MAX_TOP as MAX_TOP.
// Flow: one word is in work at a time. While the store fills, a word goes
// straight to the divider; once full, a minimum search first reads each held
// sample from the store, and a word that replaces nothing skips the divider
// and repeats the previous average.
// The time per word is set by the one-bit-per-cycle divider and the single
// read port of the sample store.
// The finished word sits in an output register: a stalled receiver holds it
// there, and the next word is already taken and worked on; only the final
// hand-off waits for the register to free.
// Reset clears k to 5, the count, the sum and the previous average; the store
// itself is not cleared, entries past the count are never read. A word
// flagged last_item clears the sequence once its result is registered.
module running_top_k_mean #(
	parameter int MAX_TOP = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [rtkm_pkg::TOP_W-1:0]      cfg_wr_data,
	input  logic                            sample_valid,
	output logic                            sample_ready,
	input  logic signed [rtkm_pkg::SAMPLE_W-1:0] sample,
	input  logic                            last_item,
	output logic                            average_valid,
	input  logic                            average_ready,
	output logic signed [rtkm_pkg::SAMPLE_W-1:0] average
);

	import rtkm_pkg::*;
	`include "running_top_k_mean_macros.svh"

	localparam int AW = (MAX_TOP > 1) ? $clog2(MAX_TOP) : 1;
	localparam int CW = $clog2(MAX_TOP + 1);
	localparam int SUM_W = SAMPLE_W + CW;
	localparam int DCW = $clog2(SUM_W);
	localparam logic signed [SUM_W-1:0] Q_MAX = SUM_W'(32'sh7FFFFFFF);
	localparam logic signed [SUM_W-1:0] Q_MIN = SUM_W'(32'sh80000000);

	state_t state_q, state_d;

	logic [TOP_W-1:0]           top_count_q;
	logic [TOP_W-1:0]           k_eff;
	logic [TOP_W-1:0]           k_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       last_q;
	logic [CW-1:0]              seen_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic signed [SAMPLE_W-1:0] prev_q;
	logic signed [SAMPLE_W-1:0] result_q;

	// min search
	logic [AW-1:0]              rd_idx_q;
	logic                       rd_vld_s1;
	logic [AW-1:0]              rd_idx_s1;
	logic signed [SAMPLE_W-1:0] min_val_q;
	logic [AW-1:0]              min_idx_q;

	// divider
	logic [DCW-1:0]             div_cnt_q;
	logic [SUM_W-1:0]           quo_q;
	logic [TOP_W:0]             rem_q;
	logic                       neg_q;
	logic [TOP_W:0]             rem_sh;
	logic                       rem_ge;
	logic signed [SUM_W-1:0]    quo_signed;

	// output register
	logic signed [SAMPLE_W-1:0] avg_q;
	logic                       avg_vld_q;
	logic                       out_free;

	// store port
	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [SAMPLE_W-1:0]        ram_rdata;
	logic signed [SAMPLE_W-1:0] ram_rval;

	logic accept;
	logic append;
	logic replace;
	logic scan_last;

	assign sample_ready  = (state_q == ST_IDLE);
	assign accept        = sample_valid && sample_ready;
	assign average_valid = avg_vld_q;
	assign average       = avg_q;
	assign out_free      = !avg_vld_q || average_ready;
	assign ram_rval      = $signed(ram_rdata);

	// k as used: zero reads as one, large values clamp to the store depth
	always_comb begin
		k_eff = top_count_q;
		if (top_count_q == '0) begin
			k_eff = TOP_W'(1);
		end else if (32'(top_count_q) > MAX_TOP) begin
			k_eff = TOP_W'(MAX_TOP);
		end
	end

	assign append    = (32'(seen_q) < 32'(k_eff)) && (32'(seen_q) < MAX_TOP);
	assign replace   = sample_q > min_val_q;
	assign scan_last = (32'(rd_idx_q) + 1 == 32'(seen_q));

	assign ram_we    = (accept && append) || (state_q == ST_DECIDE && replace);
	assign ram_waddr = (state_q == ST_DECIDE) ? min_idx_q : seen_q[AW-1:0];

	rtkm_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_TOP)
	) u_best_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (state_q == ST_DECIDE ? sample_q : sample),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	// one restoring step
	assign rem_sh     = {rem_q[TOP_W-1:0], quo_q[SUM_W-1]};
	assign rem_ge     = rem_sh >= {1'b0, k_q};
	assign quo_signed = neg_q ? -$signed(quo_q) : $signed(quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = append ? ST_PREP : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_SCAN_WAIT;
				end
			end
			ST_SCAN_WAIT: state_d = ST_DECIDE;
			ST_DECIDE:    state_d = replace ? ST_PREP : ST_OUT;
			ST_PREP:      state_d = ST_DIV;
			ST_DIV: begin
				if (32'(div_cnt_q) == SUM_W - 1) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_count_q <= TOP_COUNT_RST;
			seen_q      <= '0;
			sum_q       <= '0;
			prev_q      <= '0;
			avg_vld_q   <= 1'b0;
			rd_vld_s1   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				top_count_q <= cfg_wr_data;
			end
			rd_vld_s1 <= (state_q == ST_SCAN);
			if (accept && append) begin
				seen_q <= seen_q + CW'(1);
				sum_q  <= sum_q + SUM_W'(sample);
			end
			if (state_q == ST_DECIDE && replace) begin
				sum_q <= sum_q + SUM_W'(sample_q) - SUM_W'(min_val_q);
			end
			if (average_ready) begin
				avg_vld_q <= 1'b0;
			end
			if (state_q == ST_OUT && out_free) begin
				avg_vld_q <= 1'b1;
				prev_q    <= result_q;
				if (last_q) begin
					seen_q <= '0;
					sum_q  <= '0;
					prev_q <= '0;
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample;
			last_q   <= last_item;
			k_q      <= k_eff;
			rd_idx_q <= '0;
		end
		if (state_q == ST_SCAN) begin
			rd_idx_q <= rd_idx_q + AW'(1);
		end
		rd_idx_s1 <= rd_idx_q;
		// running minimum, lowest index wins on ties
		if (rd_vld_s1 && (rd_idx_s1 == '0 || ram_rval < min_val_q)) begin
			min_val_q <= ram_rval;
			min_idx_q <= rd_idx_s1;
		end
		if (state_q == ST_DECIDE && !replace) begin
			result_q <= prev_q;
		end
		if (state_q == ST_PREP) begin
			neg_q     <= sum_q[SUM_W-1];
			quo_q     <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
			rem_q     <= '0;
			div_cnt_q <= '0;
		end
		if (state_q == ST_DIV) begin
			rem_q     <= rem_ge ? rem_sh - {1'b0, k_q} : rem_sh;
			quo_q     <= {quo_q[SUM_W-2:0], rem_ge};
			div_cnt_q <= div_cnt_q + DCW'(1);
		end
		if (state_q == ST_FIN) begin
			if (quo_signed > Q_MAX) begin
				result_q <= Q_MAX[SAMPLE_W-1:0];
			end else if (quo_signed < Q_MIN) begin
				result_q <= Q_MIN[SAMPLE_W-1:0];
			end else begin
				result_q <= quo_signed[SAMPLE_W-1:0];
			end
		end
		if (state_q == ST_OUT && out_free) begin
			avg_q <= result_q;
		end
	end

	`RTKM_ASSERT_NOW(a_seen_bound, clk, arst_n, 1'b1, 32'(seen_q) <= MAX_TOP)
	`RTKM_ASSERT_NOW(a_scan_nonempty, clk, arst_n, state_q == ST_SCAN, seen_q != '0)
	`RTKM_ASSERT_NOW(a_rem_below_k, clk, arst_n, state_q == ST_DIV, rem_q < {1'b0, k_q})
	`RTKM_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, state_q != ST_IDLE)

endmodule

FILE: rtl/rtkm_ram.sv
`timescale 1ns / 1ps

module rtkm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

import rtkm_pkg::*;

// Tracks the k largest samples of the running sequence and keeps a queue of
// the averages the block owes us, oldest first.
class top_k_mean_scoreboard;
	localparam int DEPTH = 16;

	logic signed [SAMPLE_W-1:0] best [DEPTH];
	int unsigned held;
	longint top_sum;                      // 37 bits would do, 64 is simpler
	logic signed [SAMPLE_W-1:0] last_average;
	logic [TOP_W-1:0] top_count;
	logic signed [SAMPLE_W-1:0] expected_averages [$];
	int errors;

	function void clear_sequence();
		held = 0;
		top_sum = 0;
		last_average = '0;
	endfunction

	function void reset_state();
		top_count = TOP_COUNT_RST;
		errors = 0;
		expected_averages.delete();
		clear_sequence();
	endfunction

	function void set_top_count(logic [TOP_W-1:0] value);
		top_count = value;
	endfunction

	function int pending();
		return expected_averages.size();
	endfunction

	// k of zero counts as one, k above the store depth as the depth
	function int effective_k();
		if (top_count == 0)
			return 1;
		if (top_count > DEPTH)
			return DEPTH;
		return int'(top_count);
	endfunction

	// truncating division, clipped to the 32-bit range
	function logic signed [SAMPLE_W-1:0] clipped_mean(longint total, int k);
		longint q;
		q = total / longint'(k);
		if (q > longint'(32'sh7FFFFFFF))
			q = longint'(32'sh7FFFFFFF);
		if (q < longint'(32'sh80000000))
			q = longint'(32'sh80000000);
		return q[SAMPLE_W-1:0];
	endfunction

	function void note_sample(logic signed [SAMPLE_W-1:0] value, logic is_last);
		int k;
		int min_idx;
		logic signed [SAMPLE_W-1:0] avg;
		k = effective_k();
		avg = last_average;
		if (held < k && held < DEPTH) begin
			best[held] = value;
			held++;
			top_sum += longint'(value);
			avg = clipped_mean(top_sum, k);
		end else begin
			min_idx = 0;
			for (int i = 1; i < held; i++)
				if (best[i] < best[min_idx])
					min_idx = i;
			if (held > 0 && value > best[min_idx]) begin
				top_sum += longint'(value) - longint'(best[min_idx]);
				best[min_idx] = value;
				avg = clipped_mean(top_sum, k);
			end
		end
		last_average = avg;
		expected_averages.push_back(avg);
		if (is_last)
			clear_sequence();
	endfunction

	function void check_average(logic signed [SAMPLE_W-1:0] got);
		logic signed [SAMPLE_W-1:0] want;
		if (expected_averages.size() == 0) begin
			$error("average: unexpected word %0d, nothing pending", got);
			errors++;
			return;
		end
		want = expected_averages.pop_front();
		if (got !== want) begin
			$error("average: expected %0d, actual %0d", want, got);
			errors++;
		end
	endfunction
endclass

module tb_top;
	localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7FFFFFFF;
	localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh80000000;
	localparam int TAIL_CYCLES = 200;        // well past one word's worst latency
	localparam int RANDOM_PER_PHASE = 290;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [TOP_W-1:0] cfg_wr_data = '0;
	logic sample_valid = 1'b0;
	logic sample_ready;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic last_item = 1'b0;
	logic average_valid;
	logic average_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] average;

	// idle odds in percent, changed per phase by the stimulus
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	top_k_mean_scoreboard sb = new;

	running_top_k_mean uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.last_item    (last_item),
		.average_valid(average_valid),
		.average_ready(average_ready),
		.average      (average)
	);

	always #10 clk = ~clk;

	// Result side. Runs in the active region of the edge, so it sees the
	// pre-edge values of everything the block and the driver put out.
	// Ready is re-rolled every cycle; a stalled word must hold.
	always @(posedge clk) begin
		if (arst_n && average_valid && average_ready)
			sb.check_average(average);
		average_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Offer one word, idling first with the sender's odds, and hold it until
	// taken. Valid is left high so back-to-back words never drop it; the
	// idle loop or the drain lowers it.
	task automatic send_word(input logic signed [SAMPLE_W-1:0] value, input logic is_last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= value;
		last_item <= is_last;
		do
			@(posedge clk);
		while (!sample_ready);
		sb.note_sample(value, is_last);
	endtask

	// Stop sending and wait until every owed average is back. One word in,
	// one word out, so the block is idle afterwards.
	task automatic drain_results();
		sample_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Only called with the block idle (after reset or after a drain).
	task automatic write_top_count(input logic [TOP_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_top_count(value);
	endtask

	// k for a new setting: extremes a quarter of the time
	function automatic logic [TOP_W-1:0] pick_top_count();
		if ($urandom_range(0, 3) == 0) begin
			case ($urandom_range(0, 3))
				0: return TOP_W'(0);
				1: return TOP_W'(1);
				2: return TOP_W'(16);
				default: return TOP_W'(31);
			endcase
		end
		return TOP_W'($urandom_range(0, 31));
	endfunction

	// Sample flavors, chosen per sequence:
	//   0 full 32-bit random, 1 tiny range (lots of ties),
	//   2 rail values (drives saturation once k drops), 3 random magnitude.
	function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int flavor);
		case (flavor)
			0: return $urandom;
			1: return int'($urandom_range(0, 8)) - 4;
			2: begin
				case ($urandom_range(0, 5))
					0: return S_MAX;
					1: return S_MAX - 1;
					2: return S_MIN;
					3: return S_MIN + 1;
					4: return '0;
					default: return -1;
				endcase
			end
			default: return $signed($urandom) >>> $urandom_range(0, 31);
		endcase
	endfunction

	// Hand-picked words: reset k, truncation toward zero, replace vs. repeat,
	// ties, k of zero and above the depth, k lowered and raised in the middle
	// of a sequence, and clipping at both rails.
	task automatic run_directed();
		// k = 5 straight out of reset
		send_word(S_MAX, 1'b0);
		send_word(S_MIN, 1'b0);
		send_word(0, 1'b0);
		send_word(1, 1'b0);
		send_word(-1, 1'b0);        // store full, sum -1 -> 0, not -1
		send_word(S_MAX, 1'b0);     // knocks out the most negative
		send_word(-5, 1'b0);        // below min, repeats
		send_word(-7, 1'b1);        // repeats, then sequence clears
		drain_results();

		// k zero counts as one; equal value does not replace
		write_top_count(TOP_W'(0));
		send_word(5, 1'b0);
		send_word(5, 1'b0);
		send_word(7, 1'b1);
		drain_results();

		// two rails low, then k lowered to 1: quotient clips low
		write_top_count(TOP_W'(2));
		send_word(S_MIN, 1'b0);
		send_word(S_MIN, 1'b0);
		drain_results();
		write_top_count(TOP_W'(1));
		send_word(S_MIN + 1, 1'b0);
		send_word(-3, 1'b0);
		drain_results();
		// k raised again: store grows while count is below the new k
		write_top_count(TOP_W'(3));
		send_word(S_MAX, 1'b0);
		send_word(S_MAX, 1'b1);
		drain_results();

		// same on the high rail
		write_top_count(TOP_W'(2));
		send_word(S_MAX, 1'b0);
		send_word(S_MAX - 1, 1'b0);
		drain_results();
		write_top_count(TOP_W'(1));
		send_word(S_MAX, 1'b1);
		drain_results();

		// k above the depth saturates to 16
		write_top_count(TOP_W'(31));
		send_word(-9, 1'b0);
		send_word(9, 1'b1);
		drain_results();
	endtask

	// Random sequences in batches; each batch starts with a drain and a new
	// k. Batches cut sequences anywhere, so k often changes mid-sequence.
	task automatic run_random(input int word_count);
		int sent;
		int seq_left;
		int flavor;
		int batch;
		sent = 0;
		seq_left = 0;
		flavor = 0;
		while (sent < word_count) begin
			drain_results();
			write_top_count(pick_top_count());
			batch = $urandom_range(10, 60);
			repeat (batch) begin
				if (seq_left == 0) begin
					seq_left = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3)
					                                       : $urandom_range(4, 40);
					flavor = $urandom_range(0, 3);
				end
				seq_left--;
				send_word(pick_sample(flavor), seq_left == 0);
				sent++;
			end
		end
	endtask

	initial begin
		sb.reset_state();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 17;
		recv_idle_pct = 73;
		run_directed();
		run_random(RANDOM_PER_PHASE);

		send_idle_pct = 73;
		recv_idle_pct = 17;
		run_random(RANDOM_PER_PHASE);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(RANDOM_PER_PHASE);

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// hang guard: far beyond the slowest legal run
	initial begin
		#(20_000_000);
		$display("tb: failure");
		$finish;
	end
endmodule

FILE: sim.f
+incdir+rtl
rtl/rtkm_pkg.sv
rtl/rtkm_ram.sv
rtl/running_top_k_mean.sv
tb/tb_top.sv
